// File: hdl/arrt_pkg.sv
// ----------------------------------------------------------------------------
// Address range reservation table package
// Types, codes and sizing constants shared by the reservation table modules.
// ----------------------------------------------------------------------------
package arrt_pkg;

    localparam int ENTRIES     = 64;
    localparam int ALIGN_SHIFT = 21;
    localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W       = $clog2(ENTRIES + 1);

    localparam int ADDR_W = 48;
    localparam int END_W  = 49;
    localparam int LEN_W  = 43;
    localparam int CFG_W  = 49;
    localparam int USED_W = 7;

    localparam logic [1:0] CFG_HEAP_READY = 2'd0;
    localparam logic [1:0] CFG_HEAP_START = 2'd1;
    localparam logic [1:0] CFG_HEAP_END   = 2'd2;

    localparam logic KIND_RESERVE = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NOT_READY  = 3'd1,
        ST_MISALIGNED = 3'd2,
        ST_OUT_WINDOW = 3'd3,
        ST_OVERLAP    = 3'd4,
        ST_FULL       = 3'd5
    } t_status;

    typedef struct packed {
        logic              kind;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
    } t_req;

    typedef struct packed {
        logic [2:0]        status;
        logic [USED_W-1:0] entries_used;
    } t_res;

    typedef struct packed {
        logic              heap_ready;
        logic [ADDR_W-1:0] heap_start;
        logic [END_W-1:0]  heap_end;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic check;
        logic scan_rd;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic pre_fail;
        logic last_idx;
    } t_stat;

endpackage

// File: hdl/arrt_cfg.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the heap window settings written through the plain write port.
// ----------------------------------------------------------------------------
module arrt_cfg
    import arrt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HEAP_READY: r_cfg.heap_ready <= i_cfg_data[0];
                CFG_HEAP_START: r_cfg.heap_start <= i_cfg_data[ADDR_W-1:0];
                CFG_HEAP_END:   r_cfg.heap_end   <= i_cfg_data[END_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hdl/arrt_ctrl.sv
// ----------------------------------------------------------------------------
// Reservation table controller
// Sequences capture, window checks, the table scan and the final commit.
// ----------------------------------------------------------------------------
module arrt_ctrl
    import arrt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_stat.pre_fail ? S_COMMIT : S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_stat.last_idx) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // The last entry read is compared in this cycle.
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// File: hdl/arrt_dp.sv
// ----------------------------------------------------------------------------
// Reservation table datapath
// Entry memories, valid bits, scan compare, accumulators and result register.
// ----------------------------------------------------------------------------
module arrt_dp
    import arrt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_req i_req,
    input  t_cfg i_cfg,
    input  t_cmd i_cmd,
    output t_stat o_stat,
    output logic o_done,
    output t_res o_res
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    logic [ADDR_W-1:0] r_mem_start [ENTRIES];
    logic [END_W-1:0]  r_mem_end   [ENTRIES];
    logic [ENTRIES-1:0] r_valid;
    logic [CNT_W-1:0]   r_count;

    t_req              r_req;
    t_status           r_pre;
    logic [IDX_W-1:0]  r_idx;
    logic              r_cmp_v;
    logic [IDX_W-1:0]  r_rd_idx;
    logic              r_rd_valid;
    logic [ADDR_W-1:0] r_rd_start;
    logic [END_W-1:0]  r_rd_end;

    logic              r_ovl;
    logic              r_match_f;
    logic [IDX_W-1:0]  r_match_idx;
    logic              r_free_f;
    logic [IDX_W-1:0]  r_free_idx;

    logic              r_done;
    t_res              r_res;

    logic [END_W-1:0]  hi;
    t_status           pre_status;
    logic              hit_start;
    logic              hit_cover;
    logic              same_start;
    t_status           fin_status;
    logic              wr_en;
    logic              wr_new;
    logic [IDX_W-1:0]  wr_idx;

    assign hi = {1'b0, r_req.address} + END_W'(r_req.length);

    always_comb begin
        if (!i_cfg.heap_ready) begin
            pre_status = ST_NOT_READY;
        end else if (r_req.kind == KIND_RELEASE) begin
            pre_status = ST_OK;
        end else if ((r_req.address[ALIGN_SHIFT-1:0] != '0) ||
                     (r_req.length[ALIGN_SHIFT-1:0] != '0)) begin
            pre_status = ST_MISALIGNED;
        end else if ((r_req.address < i_cfg.heap_start) || (hi > i_cfg.heap_end)) begin
            pre_status = ST_OUT_WINDOW;
        end else begin
            pre_status = ST_OK;
        end
    end

    assign o_stat.pre_fail = (pre_status != ST_OK);
    assign o_stat.last_idx = (r_idx == LAST_IDX);

    // Per-entry compare on the registered read data.
    assign hit_start  = (r_rd_start >= r_req.address) && ({1'b0, r_rd_start} < hi);
    assign hit_cover  = (r_rd_start < r_req.address) && ({1'b0, r_req.address} < r_rd_end);
    assign same_start = (r_rd_start == r_req.address);

    always_comb begin
        wr_en  = 1'b0;
        wr_new = 1'b0;
        wr_idx = r_free_idx;
        if (r_pre != ST_OK) begin
            fin_status = r_pre;
        end else if (r_req.kind == KIND_RELEASE) begin
            fin_status = ST_OK;
        end else if (r_ovl) begin
            fin_status = ST_OVERLAP;
        end else if (r_match_f) begin
            fin_status = ST_OK;
            wr_en      = 1'b1;
            wr_idx     = r_match_idx;
        end else if (r_free_f) begin
            fin_status = ST_OK;
            wr_en      = 1'b1;
            wr_new     = 1'b1;
        end else begin
            fin_status = ST_FULL;
        end
    end

    // Entry memories: one read and one write port each.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_rd) begin
            r_rd_start <= r_mem_start[r_idx];
            r_rd_end   <= r_mem_end[r_idx];
        end
        if (i_cmd.commit && wr_en) begin
            r_mem_start[wr_idx] <= r_req.address;
            r_mem_end[wr_idx]   <= hi;
        end
    end

    // Payload and scan bookkeeping.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.check) begin
            r_pre       <= pre_status;
            r_idx       <= '0;
            r_ovl       <= 1'b0;
            r_match_f   <= 1'b0;
            r_match_idx <= '0;
            r_free_f    <= 1'b0;
            r_free_idx  <= '0;
        end else begin
            if (i_cmd.scan_rd) begin
                r_idx      <= r_idx + 1'b1;
                r_rd_idx   <= r_idx;
                r_rd_valid <= r_valid[r_idx];
            end
            if (r_cmp_v) begin
                if (r_rd_valid) begin
                    if (hit_start || hit_cover) begin
                        r_ovl <= 1'b1;
                    end
                    if (same_start && !r_match_f) begin
                        r_match_f   <= 1'b1;
                        r_match_idx <= r_rd_idx;
                    end
                end else if (!r_free_f) begin
                    r_free_f   <= 1'b1;
                    r_free_idx <= r_rd_idx;
                end
            end
        end
        if (i_cmd.commit) begin
            r_res.status <= fin_status;
            r_res.entries_used <= USED_W'(wr_new ? r_count + 1'b1 : r_count);
        end
    end

    // Control state: valid bits, count, compare pipeline flag, result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            r_cmp_v <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_cmp_v <= i_cmd.scan_rd;
            r_done  <= i_cmd.commit;
            if (r_cmp_v && (r_req.kind == KIND_RELEASE) && r_rd_valid && same_start) begin
                r_valid[r_rd_idx] <= 1'b0;
                r_count           <= r_count - 1'b1;
            end
            if (i_cmd.commit && wr_new) begin
                r_valid[wr_idx] <= 1'b1;
                r_count         <= r_count + 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// File: hdl/address_range_reservation_table_top.sv
// ----------------------------------------------------------------------------
// Address range reservation table
// Checks and records reserved address ranges inside a configured heap window.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A request that fails
// the ready, alignment or window check skips the scan and goes from check
// straight to commit. Any other request scans every entry of the table, one
// entry per clock through the single read port of the entry memory, then
// goes through drain and commit. Busy is high in check, scan, drain and
// commit. The answer is on o_res for exactly one cycle,
// marked by o_done, and the receiver has no way to stall it, so it must
// capture the item in that cycle. A new request may be issued in the same
// cycle as o_done. Configuration is written through i_cfg_we, i_cfg_idx and
// i_cfg_data (0 heap ready, 1 heap start, 2 heap end) and should only change
// while the block is idle.
// ----------------------------------------------------------------------------
module address_range_reservation_table_top
    import arrt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_req             i_req,
    output logic             o_done,
    output t_res             o_res,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;

    // Heap window settings.
    arrt_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // The controller steps each item through check, then scan and drain unless a check fails, then commit.
    arrt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // The datapath holds the table and produces the result item.
    arrt_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cfg   (cfg),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_done  (o_done),
        .o_res   (o_res)
    );

endmodule

// File: tb/sv/address_range_reservation_table_top_tb.sv
// ----------------------------------------------------------------------------
// Address range reservation table testbench
// Sends reserve and release requests through the start/busy port and checks
// every answer against a predictor of the range table kept in the bench. It
// moves the heap window between runs and uses both dense and sparse traffic.
// ----------------------------------------------------------------------------
module address_range_reservation_table_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import arrt_pkg::*;

    // One allocation unit and the values that bound the heap window.
    localparam logic [ADDR_W-1:0] UNIT       = ADDR_W'(1) << ALIGN_SHIFT;
    localparam logic [ADDR_W-1:0] ALIGN_MASK = UNIT - ADDR_W'(1);
    localparam logic [END_W-1:0]  WIN_TOP    = END_W'(1) << ADDR_W;
    localparam logic [LEN_W-1:0]  LEN_TOP    = LEN_W'(1) << (LEN_W - 1);
    localparam logic [ADDR_W-1:0] FILL_BASE  = ADDR_W'(1) << 44;

    // Quiet cycles allowed before the run is declared hung. The slowest
    // legal stretch is a full table scan plus a sender gap or a phase change.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1000;

    // ------------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------------
    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             start      = 1'b0;
    logic             busy;
    t_req             i_req      = '0;
    logic             o_done;
    t_res             o_res;
    logic             i_cfg_we   = 1'b0;
    logic [1:0]       i_cfg_idx  = CFG_HEAP_READY;
    logic [CFG_W-1:0] i_cfg_data = '0;

    address_range_reservation_table_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_done     (o_done),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_req req_q[$];          // requests waiting to be offered to the block
    t_res answer_q[$];       // predicted answers, oldest first
    logic req_taken   = 1'b0; // the offered item was taken at the last edge
    int   idle_pct    = 0;    // chance in a hundred that the sender holds back
    int   quiet_cycles = 0;
    int   err_count   = 0;
    int   items_sent  = 0;
    int   items_taken = 0;
    int   answers_seen = 0;
    int   status_count [6];

    // Predictor copy of the configuration and of the range table.
    logic              mdl_ready;
    logic [ADDR_W-1:0] mdl_heap_start;
    logic [END_W-1:0]  mdl_heap_end;
    logic              mdl_valid [ENTRIES];
    logic [ADDR_W-1:0] mdl_start [ENTRIES];
    logic [END_W-1:0]  mdl_end   [ENTRIES];
    int                mdl_used;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // A reserve goes through ready, alignment, window, overlap and then slot
    // checks, in that order. A stored range with the same start is updated in
    // place, which can only happen for a zero length request since any
    // longer request sees that start inside its own span.
    function automatic t_status rsv_reserve(logic [ADDR_W-1:0] addr,
                                            logic [LEN_W-1:0]  len);
        logic [END_W-1:0] hi;
        int               match_idx;
        int               free_idx;
        hi        = END_W'(addr) + END_W'(len);
        match_idx = -1;
        free_idx  = -1;
        if (!mdl_ready)
            return ST_NOT_READY;
        if ((addr & ALIGN_MASK) != '0 || (len & LEN_W'(ALIGN_MASK)) != '0)
            return ST_MISALIGNED;
        if (addr < mdl_heap_start || hi > mdl_heap_end)
            return ST_OUT_WINDOW;
        // A stored start inside the new span, or a stored range that covers
        // the new start strictly after its own start, is a collision. Empty
        // stored ranges can only collide through their start.
        for (int i = 0; i < ENTRIES; i++) begin
            if (mdl_valid[i]) begin
                if (mdl_start[i] >= addr && END_W'(mdl_start[i]) < hi)
                    return ST_OVERLAP;
                if (mdl_start[i] < addr && END_W'(addr) < mdl_end[i])
                    return ST_OVERLAP;
            end
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (mdl_valid[i]) begin
                if (mdl_start[i] == addr && match_idx < 0)
                    match_idx = i;
            end else if (free_idx < 0) begin
                free_idx = i;
            end
        end
        if (match_idx >= 0) begin
            mdl_end[match_idx] = hi;
            return ST_OK;
        end
        if (free_idx < 0)
            return ST_FULL;
        mdl_valid[free_idx] = 1'b1;
        mdl_start[free_idx] = addr;
        mdl_end[free_idx]   = hi;
        mdl_used++;
        return ST_OK;
    endfunction

    // A release succeeds whenever the heap is ready, matching or not.
    function automatic t_status rsv_release(logic [ADDR_W-1:0] addr);
        if (!mdl_ready)
            return ST_NOT_READY;
        for (int i = 0; i < ENTRIES; i++) begin
            if (mdl_valid[i] && mdl_start[i] == addr) begin
                mdl_valid[i] = 1'b0;
                mdl_used--;
            end
        end
        return ST_OK;
    endfunction

    function automatic t_res rsv_step(t_req req);
        t_res r;
        if (req.kind == KIND_RESERVE)
            r.status = rsv_reserve(req.address, req.length);
        else
            r.status = rsv_release(req.address);
        r.entries_used = USED_W'(mdl_used);
        return r;
    endfunction

    function automatic void rsv_config(logic [1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            CFG_HEAP_READY: mdl_ready      = data[0];
            CFG_HEAP_START: mdl_heap_start = data[ADDR_W-1:0];
            CFG_HEAP_END:   mdl_heap_end   = data[END_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void rsv_clear();
        mdl_ready      = 1'b0;
        mdl_heap_start = '0;
        mdl_heap_end   = '0;
        mdl_used       = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            mdl_valid[i] = 1'b0;
            mdl_start[i] = '0;
            mdl_end[i]   = '0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offers the next pending item on the falling edge. An offered
    // item stays on the port until the block takes it; the next item can
    // follow directly without start dropping in between.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drv
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !req_taken) begin
            // Still waiting for the block to take the offered item.
        end else if (req_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
            i_req <= req_q.pop_front();
            start <= 1'b1;
        end else begin
            start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: on each rising edge it applies register writes to the
    // predictor, checks an answer if one is strobed, and predicts the answer
    // for an item taken at this edge. Answers cannot be held off, so each one
    // is checked in the single cycle it is shown.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : mon
        t_res want;
        if (!i_rst_n) begin
            rsv_clear();
            req_taken    <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            if (i_cfg_we)
                rsv_config(i_cfg_idx, i_cfg_data);
            if (o_done) begin
                answers_seen++;
                if (o_res.status < 6)
                    status_count[o_res.status]++;
                if (answer_q.size() == 0) begin
                    err_count++;
                    $display("%0t: answer with none predicted: status %0d used %0d",
                             $time, o_res.status, o_res.entries_used);
                end else begin
                    want = answer_q.pop_front();
                    if (o_res.status !== want.status) begin
                        err_count++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, o_res.status);
                    end
                    if (o_res.entries_used !== want.entries_used) begin
                        err_count++;
                        $display("%0t: entries_used expected %0d actual %0d",
                                 $time, want.entries_used, o_res.entries_used);
                    end
                end
            end
            if (start && !busy) begin
                answer_q.push_back(rsv_step(i_req));
                items_taken++;
            end
            req_taken    <= start && !busy;
            quiet_cycles <= (o_done || i_cfg_we || (start && !busy)) ? 0 : quiet_cycles + 1;
        end
    end

    // Watchdog: a run that stops making progress ends here.
    initial begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge i_clk);
        $display("address_range_reservation_table_top_tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_req(logic kind, logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len);
        t_req r;
        r.kind    = kind;
        r.address = addr;
        r.length  = len;
        req_q.push_back(r);
        items_sent++;
    endtask

    // Waits until every queued item has been taken and answered, then lets a
    // full scan's worth of cycles pass so the block is surely at rest.
    task automatic wait_drained();
        do
            @(posedge i_clk);
        while (req_q.size() != 0 || start || answer_q.size() != 0);
        repeat (ENTRIES + 4) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic set_window(logic ready, logic [ADDR_W-1:0] lo, logic [END_W-1:0] hi);
        write_cfg(CFG_HEAP_READY, CFG_W'(ready));
        write_cfg(CFG_HEAP_START, CFG_W'(lo));
        write_cfg(CFG_HEAP_END, CFG_W'(hi));
        @(posedge i_clk);
    endtask

    // Releases every range the predictor holds. Only called while drained,
    // so the predictor matches the block.
    task automatic clear_ranges();
        for (int i = 0; i < ENTRIES; i++)
            if (mdl_valid[i])
                push_req(KIND_RELEASE, mdl_start[i], LEN_W'($urandom));
    endtask

    // Mostly aligned requests near the window so that ranges collide, fill
    // the table and get released; a share of them break one rule or carry
    // fully random bits.
    task automatic random_batch(int n, logic [ADDR_W-1:0] base, int span);
        logic [ADDR_W-1:0] a;
        logic [LEN_W-1:0]  l;
        logic              k;
        int                sel;
        longint            off;
        for (int j = 0; j < n; j++) begin
            sel = $urandom_range(99);
            off = longint'($urandom_range(span + 3)) - 2;
            a   = base + ADDR_W'(off << ALIGN_SHIFT);
            l   = LEN_W'($urandom_range(4)) << ALIGN_SHIFT;
            k   = (sel >= 62) ? KIND_RELEASE : KIND_RESERVE;
            if (sel < 8) begin
                a = ADDR_W'({$urandom, $urandom});
                l = LEN_W'({$urandom, $urandom});
                k = 1'($urandom_range(1));
            end else if (sel < 12) begin
                l = l | LEN_W'($urandom_range(1, (1 << ALIGN_SHIFT) - 1));
            end else if (sel < 15) begin
                a = a | ADDR_W'($urandom_range(1, (1 << ALIGN_SHIFT) - 1));
            end else if (sel == 15) begin
                l = LEN_TOP;
            end else if (sel < 19) begin
                l = LEN_W'($urandom_range(span)) << ALIGN_SHIFT;
            end else if (k == KIND_RELEASE) begin
                l = LEN_W'({$urandom, $urandom});
            end
            push_req(k, a, l);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : stim
        int                random_first;
        int                phase;
        int                span;
        int                idle_choice [3];
        logic              ready;
        logic [ADDR_W-1:0] lo;
        logic [END_W-1:0]  hi;

        idle_choice[0] = 0;
        idle_choice[1] = 79;
        idle_choice[2] = 9;
        foreach (status_count[i])
            status_count[i] = 0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Right after reset the heap is not ready: both kinds are refused.
        push_req(KIND_RESERVE, '0, '0);
        push_req(KIND_RELEASE, '0, '0);
        wait_drained();

        // Widest window. Alignment is checked before the window, a range
        // may end exactly at the window end, and collisions are checked on
        // both the stored start and a stored range covering the new start.
        set_window(1'b1, '0, WIN_TOP);
        push_req(KIND_RESERVE, ADDR_W'(1), '0);
        push_req(KIND_RESERVE, '0, LEN_W'(1));
        push_req(KIND_RESERVE, '1, '1);
        push_req(KIND_RESERVE, ADDR_W'(WIN_TOP - END_W'(UNIT)), LEN_W'(UNIT));
        push_req(KIND_RESERVE, ADDR_W'(WIN_TOP - END_W'(UNIT)), LEN_W'(UNIT) << 1);
        push_req(KIND_RESERVE, '0, LEN_TOP);
        push_req(KIND_RESERVE, UNIT, LEN_W'(UNIT));
        // Same start with zero length shrinks the stored range to nothing.
        push_req(KIND_RESERVE, '0, '0);
        push_req(KIND_RESERVE, UNIT, LEN_W'(UNIT));
        push_req(KIND_RESERVE, '0, LEN_W'(UNIT) << 1);
        // Zero length right at the end of a stored range is allowed, but not
        // strictly inside one.
        push_req(KIND_RESERVE, UNIT << 1, '0);
        push_req(KIND_RESERVE, UNIT << 2, LEN_W'(UNIT) << 2);
        push_req(KIND_RESERVE, (UNIT << 2) + (UNIT << 1), '0);
        // Releases succeed with or without a matching start.
        push_req(KIND_RELEASE, '0, '0);
        push_req(KIND_RELEASE, ADDR_W'(3), '0);
        push_req(KIND_RELEASE, '1, '1);
        wait_drained();

        // Highest window start: everything aligned falls below it.
        set_window(1'b1, '1, WIN_TOP);
        push_req(KIND_RESERVE, ADDR_W'(WIN_TOP - END_W'(UNIT)), LEN_W'(UNIT));
        push_req(KIND_RESERVE, '1, '0);
        wait_drained();

        // Empty window: only a zero length range at address zero fits.
        set_window(1'b1, '0, '0);
        push_req(KIND_RESERVE, '0, '0);
        push_req(KIND_RESERVE, '0, LEN_W'(UNIT));
        wait_drained();
        write_cfg(CFG_HEAP_READY, '0);
        @(posedge i_clk);
        push_req(KIND_RELEASE, UNIT, '0);
        wait_drained();

        // Fill the table to the last slot and beyond. A same-start update
        // still works while full; a new start does not.
        idle_choice[0] = 0;
        set_window(1'b1, FILL_BASE, END_W'(FILL_BASE) + (END_W'(UNIT) * END_W'(200)));
        clear_ranges();
        wait_drained();
        idle_pct = 9;
        for (int i = 0; i < ENTRIES + 6; i++)
            push_req(KIND_RESERVE, FILL_BASE + UNIT * ADDR_W'(2 * i), LEN_W'(UNIT));
        push_req(KIND_RESERVE, FILL_BASE, '0);
        push_req(KIND_RESERVE, FILL_BASE + UNIT, '0);
        push_req(KIND_RELEASE, FILL_BASE, '0);
        push_req(KIND_RESERVE, FILL_BASE + UNIT, LEN_W'(UNIT));
        push_req(KIND_RESERVE, FILL_BASE + UNIT * ADDR_W'(141), LEN_W'(UNIT));
        wait_drained();
        clear_ranges();
        wait_drained();

        // Random phases. Each one moves the window, and every second one changes how
        // often the sender idles; some pause mid-way and some end with a sweep of releases.
        random_first = items_sent;
        phase = 0;
        while (items_sent - random_first < RANDOM_ITEMS) begin
            span     = $urandom_range(160, 40);
            idle_pct = idle_choice[(phase / 2) % 3];
            ready    = 1'b1;
            lo       = ADDR_W'({$urandom, $urandom}) & ~ALIGN_MASK;
            case (phase % 6)
                0: lo = '0;
                2: lo = ADDR_W'(WIN_TOP - (END_W'(span) << ALIGN_SHIFT));
                3: lo = lo | ADDR_W'($urandom_range(1, (1 << ALIGN_SHIFT) - 1));
                4: ready = 1'b0;
                default: ;
            endcase
            hi = END_W'(lo) + (END_W'((phase % 6 == 5) ? span / 2 : span) << ALIGN_SHIFT);
            if (hi > WIN_TOP)
                hi = WIN_TOP;
            set_window(ready, lo, hi);
            random_batch(ready ? 60 : 15, lo & ~ALIGN_MASK, span);
            if ($urandom_range(1)) begin
                wait_drained();
                random_batch(30, lo & ~ALIGN_MASK, span);
            end
            wait_drained();
            if (ready && phase % 2 == 1) begin
                clear_ranges();
                wait_drained();
            end
            phase++;
        end

        wait_drained();
        $display("Run covered %0d items over %0d random phases, %0d answers checked.",
                 items_taken, phase, answers_seen);
        $display("Answers: ok %0d, not ready %0d, misaligned %0d, out of window %0d, overlap %0d, full %0d.",
                 status_count[ST_OK], status_count[ST_NOT_READY],
                 status_count[ST_MISALIGNED], status_count[ST_OUT_WINDOW],
                 status_count[ST_OVERLAP], status_count[ST_FULL]);
        if (err_count == 0)
            $display("address_range_reservation_table_top_tb: PASS");
        else
            $display("address_range_reservation_table_top_tb: FAIL");
        $finish;
    end

endmodule
